// ===== rtl/core/assert_macros.svh =====
// assertion macros for the rtl files, included by the fft top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every rising edge of clk, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/r2fft_pkg.sv =====
// shared types, constants and arithmetic helpers of the radix-2 fft
package r2fft_pkg;

  // field widths
  localparam int FUNC_W   = 2;
  localparam int INDEX_W  = 10;
  localparam int SAMPLE_W = 16;
  localparam int DATA_W   = 28;
  localparam int CFG_W    = 4;
  localparam int TW_W     = 18;
  localparam int PROD_W   = DATA_W + TW_W;
  localparam int RND_W    = PROD_W - 15;
  localparam int V_W      = RND_W + 1;
  localparam int SUM_W    = V_W + 1;
  localparam int WORD_W   = 2 * DATA_W;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd10;
  localparam real TWO_PI = 2.0 * 3.14159265358979323846;

  // operation codes of an input beat
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD      = 2'd0,
    FUNC_TRANSFORM = 2'd1,
    FUNC_READ      = 2'd2,
    FUNC_NONE      = 2'd3
  } func_t;

  // kinds of an output beat
  typedef enum logic {
    KIND_DONE = 1'b0,
    KIND_BIN  = 1'b1
  } kind_t;

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // q2.15 twiddle value, rounded half away from zero
  function automatic logic signed [TW_W-1:0] q15_round(input real x);
    real y;
    logic signed [TW_W-1:0] r;
    y = x * 32768.0;
    if (y >= 0.0) begin
      r = TW_W'($rtoi(y + 0.5));
    end else begin
      r = -TW_W'($rtoi(-y + 0.5));
    end
    return r;
  endfunction

  // product rounded to integer: floor((p + 2^14) / 2^15)
  function automatic logic signed [RND_W-1:0] round_q15(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_W'(16384);
    return t[PROD_W-1:15];
  endfunction

  // clamp a butterfly sum to the signed 28-bit range
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SUM_W'(DATA_MAX)) begin
      r = DATA_MAX;
    end else if (v < SUM_W'(DATA_MIN)) begin
      r = DATA_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/radix2_fft_in_place_top.sv =====
// in-place radix-2 decimation-in-time fft over one sample memory
// A load beat writes one complex sample into the point memory. A read beat loads its bin
// into the read registers and then the output register, and input stalls while the read
// is pending. A transform beat works on the first N = 2^log2_points entries (clamped to
// MAX_POINTS) and keeps input stalled until its done beat: a bit-reversal
// sweep over the N entries with a read and two writes for each swapped pair, then
// (N/2)*log2(N) butterflies and the done beat; a single point skips the sweep and the
// butterflies. The point memory has one write port, so every butterfly writes its two
// results back in separate states after its read, multiply and sum states. The twiddle
// rom is built at elaboration; results are unscaled and every butterfly output saturates
// to 28 bits. Never written entries read back as unknown data.
module radix2_fft_in_place_top #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [r2fft_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [r2fft_pkg::FUNC_W-1:0]         func,
  input  logic [r2fft_pkg::INDEX_W-1:0]        index,
  input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_real,
  input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_imag,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 kind,
  output logic [r2fft_pkg::INDEX_W-1:0]        bin_index,
  output logic signed [r2fft_pkg::DATA_W-1:0]  bin_real,
  output logic signed [r2fft_pkg::DATA_W-1:0]  bin_imag
);
  import r2fft_pkg::*;

  localparam int AW       = $clog2(MAX_POINTS);
  localparam int KW       = $clog2(AW + 1);
  localparam int TW_DEPTH = MAX_POINTS / 2;
  localparam int TWA      = (AW > 1) ? AW - 1 : 1;
  localparam logic [INDEX_W-1:0] IDX_MASK = INDEX_W'(MAX_POINTS - 1);

  typedef logic signed [TW_W-1:0] tw_arr_t [TW_DEPTH];

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_REV_RD  = 10'b00_0000_0010,
    ST_REV_WR1 = 10'b00_0000_0100,
    ST_REV_WR2 = 10'b00_0000_1000,
    ST_BF_RD   = 10'b00_0001_0000,
    ST_BF_MUL  = 10'b00_0010_0000,
    ST_BF_SUM  = 10'b00_0100_0000,
    ST_BF_WR1  = 10'b00_1000_0000,
    ST_BF_WR2  = 10'b01_0000_0000,
    ST_DONE    = 10'b10_0000_0000
  } state_t;

  // twiddle tables, cos and -sin of 2*pi*m/MAX_POINTS
  function automatic tw_arr_t build_tw(input bit imag_part);
    tw_arr_t t;
    real ang;
    for (int m = 0; m < TW_DEPTH; m++) begin
      ang = TWO_PI * m / MAX_POINTS;
      t[m] = imag_part ? q15_round(-$sin(ang)) : q15_round($cos(ang));
    end
    return t;
  endfunction

  localparam tw_arr_t TW_RE = build_tw(1'b0);
  localparam tw_arr_t TW_IM = build_tw(1'b1);

  state_t              state;
  logic [CFG_W-1:0]    log2_points;
  logic [AW-1:0]       cnt;
  logic [AW-1:0]       bcnt;
  logic [KW-1:0]       stage;
  logic                rd_pend;
  logic [INDEX_W-1:0]  rd_index;

  logic [WORD_W-1:0]   mem [MAX_POINTS];
  logic [WORD_W-1:0]   rd_a;
  logic [WORD_W-1:0]   rd_b;
  logic signed [TW_W-1:0] tw_re_q;
  logic signed [TW_W-1:0] tw_im_q;

  logic signed [PROD_W-1:0] prod_rr, prod_ii, prod_ri, prod_ir;
  logic signed [DATA_W-1:0] ur_q, ui_q;
  logic signed [V_W-1:0]    vr_q, vi_q;
  logic [AW-1:0]            p_q, q_q;

  logic                in_acc;
  logic [INDEX_W-1:0]  idx10;
  logic [AW-1:0]       idx_addr;
  logic [KW-1:0]       k_eff;
  logic [AW:0]         n_pts;
  logic [AW:0]         n_m1;
  logic [AW-1:0]       last_pt;
  logic [AW-1:0]       last_bf;
  logic [AW-1:0]       rev_full;
  logic [AW-1:0]       rev_idx;
  logic [AW-1:0]       half;
  logic [AW-1:0]       i_part;
  logic [AW-1:0]       p_addr;
  logic [AW-1:0]       tw_full;
  logic [TWA-1:0]      tw_addr;
  logic                rd_en;
  logic [AW-1:0]       rd_a_addr, rd_b_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [WORD_W-1:0]   wr_data;
  logic signed [DATA_W-1:0] xr, xi;
  logic signed [SUM_W-1:0]  sum_pr, sum_pi, sum_qr, sum_qi;

  // handshake and index decode
  assign in_stall = (state != ST_IDLE) || rd_pend || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign idx10    = index & IDX_MASK;
  assign idx_addr = AW'(idx10);

  // transform size
  assign k_eff   = (log2_points > CFG_W'(AW)) ? KW'(AW) : KW'(log2_points);
  assign n_pts   = (AW + 1)'(1) << k_eff;
  assign n_m1    = n_pts - (AW + 1)'(1);
  assign last_pt = n_m1[AW-1:0];
  assign last_bf = AW'(n_m1[AW:1]);

  // bit-reversed partner of cnt over k_eff bits
  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_full[b] = cnt[AW-1-b];
    end
  end
  assign rev_idx = rev_full >> (KW'(AW) - k_eff);

  // butterfly addresses and twiddle index
  assign half    = AW'(1) << stage;
  assign i_part  = bcnt & (half - AW'(1));
  assign p_addr  = ((bcnt >> stage) << (stage + KW'(1))) | i_part;
  assign tw_full = i_part << (KW'(AW - 1) - stage);
  assign tw_addr = TWA'(tw_full);

  // read port control
  always_comb begin
    rd_en     = 1'b0;
    rd_a_addr = idx_addr;
    rd_b_addr = rev_idx;
    unique case (state)
      ST_IDLE: begin
        rd_en = in_acc && (func == FUNC_READ);
      end
      ST_REV_RD: begin
        rd_en     = cnt < rev_idx;
        rd_a_addr = cnt;
      end
      ST_BF_RD: begin
        rd_en     = 1'b1;
        rd_a_addr = p_addr;
        rd_b_addr = p_addr | half;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // butterfly sums from held operands
  assign sum_pr = SUM_W'(ur_q) + SUM_W'(vr_q);
  assign sum_pi = SUM_W'(ui_q) + SUM_W'(vi_q);
  assign sum_qr = SUM_W'(ur_q) - SUM_W'(vr_q);
  assign sum_qi = SUM_W'(ui_q) - SUM_W'(vi_q);

  // write port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_addr;
    wr_data = {DATA_W'(sample_real), DATA_W'(sample_imag)};
    unique case (state)
      ST_IDLE: begin
        wr_en = in_acc && (func == FUNC_LOAD);
      end
      ST_REV_WR1: begin
        wr_en   = 1'b1;
        wr_addr = cnt;
        wr_data = rd_b;
      end
      ST_REV_WR2: begin
        wr_en   = 1'b1;
        wr_addr = rev_idx;
        wr_data = rd_a;
      end
      ST_BF_WR1: begin
        wr_en   = 1'b1;
        wr_addr = p_q;
        wr_data = {sat_data(sum_pr), sat_data(sum_pi)};
      end
      ST_BF_WR2: begin
        wr_en   = 1'b1;
        wr_addr = q_q;
        wr_data = {sat_data(sum_qr), sat_data(sum_qi)};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // point memory, registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a <= mem[rd_a_addr];
      rd_b <= mem[rd_b_addr];
    end
  end

  // twiddle rom, read with the memory
  always_ff @(posedge clk) begin
    if (rd_en) begin
      tw_re_q <= TW_RE[tw_addr];
      tw_im_q <= TW_IM[tw_addr];
    end
  end

  // butterfly datapath
  assign xr = $signed(rd_b[WORD_W-1:DATA_W]);
  assign xi = $signed(rd_b[DATA_W-1:0]);

  always_ff @(posedge clk) begin
    if (state == ST_BF_RD) begin
      p_q <= p_addr;
      q_q <= p_addr | half;
    end
    if (state == ST_BF_MUL) begin
      prod_rr <= PROD_W'(xr) * PROD_W'(tw_re_q);
      prod_ii <= PROD_W'(xi) * PROD_W'(tw_im_q);
      prod_ri <= PROD_W'(xr) * PROD_W'(tw_im_q);
      prod_ir <= PROD_W'(xi) * PROD_W'(tw_re_q);
      ur_q    <= $signed(rd_a[WORD_W-1:DATA_W]);
      ui_q    <= $signed(rd_a[DATA_W-1:0]);
    end
    if (state == ST_BF_SUM) begin
      vr_q <= V_W'(round_q15(prod_rr)) - V_W'(round_q15(prod_ii));
      vi_q <= V_W'(round_q15(prod_ri)) + V_W'(round_q15(prod_ir));
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      log2_points <= CFG_RESET;
    end else if (cfg_wr_en) begin
      log2_points <= cfg_wr_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      bcnt  <= '0;
      stage <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc && func == FUNC_TRANSFORM) begin
            cnt   <= '0;
            bcnt  <= '0;
            stage <= '0;
            state <= (k_eff == '0) ? ST_DONE : ST_REV_RD;
          end
        end
        ST_REV_RD: begin
          if (cnt < rev_idx) begin
            state <= ST_REV_WR1;
          end else if (cnt == last_pt) begin
            state <= ST_BF_RD;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        ST_REV_WR1: begin
          state <= ST_REV_WR2;
        end
        ST_REV_WR2: begin
          if (cnt == last_pt) begin
            state <= ST_BF_RD;
          end else begin
            cnt   <= cnt + AW'(1);
            state <= ST_REV_RD;
          end
        end
        ST_BF_RD: begin
          state <= ST_BF_MUL;
        end
        ST_BF_MUL: begin
          state <= ST_BF_SUM;
        end
        ST_BF_SUM: begin
          state <= ST_BF_WR1;
        end
        ST_BF_WR1: begin
          state <= ST_BF_WR2;
        end
        ST_BF_WR2: begin
          if (bcnt == last_bf) begin
            bcnt <= '0;
            if (stage == k_eff - KW'(1)) begin
              state <= ST_DONE;
            end else begin
              stage <= stage + KW'(1);
              state <= ST_BF_RD;
            end
          end else begin
            bcnt  <= bcnt + AW'(1);
            state <= ST_BF_RD;
          end
        end
        ST_DONE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // read beat tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= in_acc && (func == FUNC_READ);
    end
    if (in_acc) begin
      rd_index <= idx10;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pend || state == ST_DONE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (rd_pend) begin
      kind      <= KIND_BIN;
      bin_index <= rd_index;
      bin_real  <= $signed(rd_a[WORD_W-1:DATA_W]);
      bin_imag  <= $signed(rd_a[DATA_W-1:0]);
    end else if (state == ST_DONE) begin
      kind      <= KIND_DONE;
      bin_index <= '0;
      bin_real  <= '0;
      bin_imag  <= '0;
    end
  end

  `include "assert_macros.svh"

  // a finished transform shows its done beat next cycle
  `ASSERT_CLK(a_done_beat, (state == ST_DONE) |=> (out_valid && kind == KIND_DONE), "done beat missing")
  // a read shows its bin next cycle
  `ASSERT_CLK(a_read_beat, rd_pend |=> (out_valid && kind == KIND_BIN), "bin beat missing")
  // a swap only moves a pair once, lower index first
  `ASSERT_CLK(a_swap_order, (state == ST_REV_WR1) |-> (cnt < rev_idx), "bad swap pair")
  // the output slot never gets overwritten while it is held
  `ASSERT_CLK(a_no_overrun, (out_valid && out_stall) |-> !(rd_pend || state == ST_DONE), "output overrun")

endmodule
